// ----- rtl/postfix_stack_evaluator_macros.svh -----
// Assertion macros used by the checker file of the evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_NOW(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_NEXT(label, ant, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pse_pkg.sv -----
`default_nettype none

package pse_pkg;

    // Datapath and stack sizing
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEP_W  = $clog2(DATA_W + 1);

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    // Decoded symbol class
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_UNKNOWN
    } op_kind_t;

    // One classified request as it sits in the queue
    typedef struct packed {
        op_kind_t    kind;
        logic [3:0]  digit;
        logic        last;
    } pse_item_t;

endpackage

`default_nettype wire

// ----- rtl/pse_ram.sv -----
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pse_div.sv -----
`default_nettype none

module pse_div
    import pse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DATA_W-1:0]     rem_reg;
    logic [DATA_W-1:0]     quo_reg;
    logic [DATA_W-1:0]     dsr_reg;
    logic                  neg_reg;
    logic [DATA_W-1:0]     quot_reg;

    logic [DATA_W:0]       shifted;
    logic [DATA_W-1:0]     diff;
    logic                  fits;

    // One restoring step on magnitudes
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted[DATA_W-1:0] - dsr_reg;
    assign fits    = (shifted >= {1'b0, dsr_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == DIV_STEP_W'(DATA_W))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + DIV_STEP_W'(1);
                end
            end
        end
    end

    // Datapath: magnitudes in, sign fixed in the final cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
            dsr_reg <= divisor[DATA_W-1] ? (~divisor + DATA_W'(1)) : divisor;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (step_reg == DIV_STEP_W'(DATA_W))
            begin
                quot_reg <= neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;
            end
            else
            begin
                rem_reg <= fits ? diff : shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], fits};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/pse_front.sv -----
`default_nettype none

module pse_front
    import pse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] symbol,
    input  wire logic       last_symbol,
    input  wire logic       push,
    output logic            full,
    output logic            q_valid,
    output pse_item_t       q_item,
    input  wire logic       q_deq
);

    pse_item_t          q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;

    pse_item_t          cls_item;
    logic [3:0]         sym_off;
    logic               do_push;
    logic               do_pop;

    // Classify the incoming symbol
    assign sym_off = symbol[3:0] - CH_ZERO[3:0];

    always_comb
    begin
        cls_item.digit = sym_off;
        cls_item.last  = last_symbol;
        if (symbol >= CH_ZERO && symbol <= CH_NINE)
        begin
            cls_item.kind = OP_DIGIT;
        end
        else
        begin
            case (symbol)
                CH_PLUS:  cls_item.kind = OP_ADD;
                CH_MINUS: cls_item.kind = OP_SUB;
                CH_STAR:  cls_item.kind = OP_MUL;
                CH_SLASH: cls_item.kind = OP_DIV;
                default:  cls_item.kind = OP_UNKNOWN;
            endcase
        end
    end

    assign full    = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_deq && q_valid;

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pse_back.sv -----
`default_nettype none

module pse_back
    import pse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire pse_item_t         q_item,
    output logic                   q_deq,
    input  wire logic              pop,
    output logic                   empty,
    output logic      [DATA_W-1:0] out_value,
    output logic      [2:0]        out_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_OPS,
        S_DIV,
        S_PUSH,
        S_EMIT
    } state_t;

    state_t             state_reg,       state_next;
    logic [CNT_W-1:0]   cnt_reg,         cnt_next;
    logic               disc_reg,        disc_next;
    pse_item_t          item_reg,        item_next;
    logic [DATA_W-1:0]  rhs_reg,         rhs_next;
    logic [DATA_W-1:0]  acc_reg,         acc_next;
    status_t            emit_st_reg,     emit_st_next;
    logic               out_valid_reg,   out_valid_next;
    logic [DATA_W-1:0]  out_value_reg,   out_value_next;
    status_t            out_status_reg,  out_status_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    logic               div_start;
    logic               div_done;
    logic [DATA_W-1:0]  div_quot;

    logic [ADDR_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]   cnt_m2;
    logic               fail;
    logic               fail_last;
    status_t            fail_code;

    assign cnt_m1 = cnt_reg[ADDR_W-1:0] - ADDR_W'(1);
    assign cnt_m2 = cnt_reg - CNT_W'(2);

    // Operand stack storage
    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Iterative divider for the / operator
    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (rhs_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        disc_next       = disc_reg;
        item_next       = item_reg;
        rhs_next        = rhs_reg;
        acc_next        = acc_reg;
        emit_st_next    = emit_st_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_deq           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[ADDR_W-1:0];
        ram_wdata       = acc_reg;
        ram_re          = 1'b0;
        ram_raddr       = cnt_m1;
        div_start       = 1'b0;
        fail            = 1'b0;
        fail_last       = 1'b0;
        fail_code       = ST_OK;

        // Result taken by the consumer
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_deq     = 1'b1;
                    item_next = q_item;
                    fail_last = q_item.last;
                    if (disc_reg)
                    begin
                        if (q_item.last)
                        begin
                            disc_next = 1'b0;
                        end
                    end
                    else if (q_item.kind == OP_DIGIT)
                    begin
                        if (cnt_reg == CNT_W'(STACK_DEPTH))
                        begin
                            fail      = 1'b1;
                            fail_code = ST_OVERFLOW;
                        end
                        else if (q_item.last)
                        begin
                            // Lone top value goes straight out
                            acc_next     = {{(DATA_W-4){1'b0}}, q_item.digit};
                            emit_st_next = ST_OK;
                            cnt_next     = '0;
                            state_next   = S_EMIT;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {{(DATA_W-4){1'b0}}, q_item.digit};
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (cnt_reg < CNT_W'(2))
                    begin
                        fail      = 1'b1;
                        fail_code = ST_UNDERFLOW;
                    end
                    else if (q_item.kind == OP_UNKNOWN)
                    begin
                        fail      = 1'b1;
                        fail_code = ST_UNKNOWN;
                    end
                    else
                    begin
                        // Fetch right operand
                        ram_re     = 1'b1;
                        state_next = S_RD2;
                    end
                end
            end

            S_RD2:
            begin
                // Right operand arrives, fetch left operand
                rhs_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = cnt_m2[ADDR_W-1:0];
                state_next = S_OPS;
            end

            S_OPS:
            begin
                cnt_next   = cnt_m2;
                fail_last  = item_reg.last;
                state_next = S_PUSH;
                case (item_reg.kind)
                    OP_ADD: acc_next = ram_rdata + rhs_reg;
                    OP_SUB: acc_next = ram_rdata - rhs_reg;
                    OP_MUL: acc_next = ram_rdata * rhs_reg;
                    OP_DIV:
                    begin
                        if (rhs_reg == '0)
                        begin
                            fail      = 1'b1;
                            fail_code = ST_DIVZERO;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        fail      = 1'b1;
                        fail_code = ST_UNKNOWN;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = div_quot;
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (item_reg.last)
                begin
                    // Pushed value is the top; emit it and clear
                    emit_st_next = ST_OK;
                    cnt_next     = '0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    ram_we     = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = acc_reg;
                    out_status_next = emit_st_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Error: clear stack, drop rest of expression, report
        if (fail)
        begin
            cnt_next     = '0;
            disc_next    = !fail_last;
            acc_next     = '0;
            emit_st_next = fail_code;
            state_next   = S_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            disc_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            item_reg       <= '0;
            rhs_reg        <= '0;
            acc_reg        <= '0;
            emit_st_reg    <= ST_OK;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            disc_reg       <= disc_next;
            out_valid_reg  <= out_valid_next;
            item_reg       <= item_next;
            rhs_reg        <= rhs_next;
            acc_reg        <= acc_next;
            emit_st_reg    <= emit_st_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
// Postfix evaluator: push ASCII bytes of a postfix expression (digits and
// + - * /, last_symbol on the final byte) and pop one result per expression,
// or one error result (value 0, status overflow, underflow, divide by zero or
// unknown symbol) after which the rest of that expression is dropped. Values
// are signed 32-bit and wrap; division truncates toward zero. A two-entry
// request queue decouples the input from the evaluation sequencer. A digit
// needs no stack read; + - * make two reads of the stack RAM (one write port,
// one registered read port), then compute and push; / also waits on the
// bit-serial divider, and the final byte of an expression moves the result
// into the output register. Bytes of a dropped expression are discarded one
// by one. The stack holds 128 values.
`default_nettype none

module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          symbol,
    input  wire logic                last_symbol,
    input  wire logic                push,
    output logic                     full,
    output logic signed [DATA_W-1:0] value,
    output logic        [2:0]        status,
    output logic                     empty,
    input  wire logic                pop
);

    logic       q_valid;
    pse_item_t  q_item;
    logic       q_deq;

    // Intake and classification
    pse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .push        (push),
        .full        (full),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_deq       (q_deq)
    );

    // Stack evaluation and result register
    pse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_deq      (q_deq),
        .pop        (pop),
        .empty      (empty),
        .out_value  (value),
        .out_status (status)
    );

endmodule

`default_nettype wire

// ----- rtl/pse_checker.sv -----
`default_nettype none
`include "postfix_stack_evaluator_macros.svh"

module pse_checker
    import pse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [2:0]        status
);

    // Status code is one of the defined codes
    `PSE_ASSERT_NOW(a_status_range, !empty, status <= ST_UNKNOWN, "status code out of range")

    // Error results carry a zero value
    `PSE_ASSERT_NOW(a_err_zero, !empty && status != ST_OK, value == '0, "error with nonzero value")

    // A result not taken stays put
    `PSE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(value) && $stable(status), "result changed while waiting")

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .value  (value),
    .status (status)
);

`default_nettype wire

// ----- verif/postfix_stack_evaluator_test.sv -----
`default_nettype none

module postfix_stack_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pse_pkg::*;

    localparam int TOTAL_SYMBOLS = 1400;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int REPORT_CAP    = 40;

    localparam logic [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } outcome_t;

    // DUT ports, all inputs known from time zero
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic [7:0]               symbol      = '0;
    logic                     last_symbol = 1'b0;
    logic                     push        = 1'b0;
    logic                     pop         = 1'b0;
    logic                     full;
    logic                     empty;
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;

    // Evaluator state mirror
    logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int                eval_depth    = 0;
    bit                eval_dropping = 1'b0;
    outcome_t          expected_results [$];

    // Bookkeeping
    int counted_symbols = 0;
    int dropped_symbols = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;
    int status_seen [5] = '{0, 0, 0, 0, 0};
    int send_gap_max    = 8;
    int rcv_gap_max     = 8;
    int recv_wait       = 0;
    int idle_cycles     = 0;

    logic [7:0] pending_bytes [$];

    postfix_stack_evaluator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .push        (push),
        .full        (full),
        .value       (value),
        .status      (status),
        .empty       (empty),
        .pop         (pop)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task expect_outcome(input logic [DATA_W-1:0] v, input status_t st);
        outcome_t o;
        o.value  = v;
        o.status = st;
        expected_results.push_back(o);
    endtask

    // Error: one result with value zero, stack cleared, rest of expression dropped
    task abort_expression(input status_t st, input logic fin);
        eval_depth    = 0;
        eval_dropping = !fin;
        expect_outcome('0, st);
    endtask

    // Advance the mirror by one accepted request
    task apply_symbol(input logic [7:0] sym, input logic fin);
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] res;
        if (eval_dropping)
        begin
            dropped_symbols++;
            if (fin)
                eval_dropping = 1'b0;
            return;
        end
        counted_symbols++;
        if (sym >= CH_ZERO && sym <= CH_NINE)
        begin
            if (eval_depth >= STACK_DEPTH)
            begin
                abort_expression(ST_OVERFLOW, fin);
                return;
            end
            eval_stack[eval_depth] = DATA_W'(sym - CH_ZERO);
            eval_depth++;
        end
        else
        begin
            // depth is checked before the byte is decoded
            if (eval_depth < 2)
            begin
                abort_expression(ST_UNDERFLOW, fin);
                return;
            end
            rhs = eval_stack[eval_depth-1];
            lhs = eval_stack[eval_depth-2];
            eval_depth -= 2;
            case (sym)
                CH_PLUS:  res = lhs + rhs;
                CH_MINUS: res = lhs - rhs;
                CH_STAR:  res = lhs * rhs;
                CH_SLASH:
                begin
                    if (rhs == 0)
                    begin
                        abort_expression(ST_DIVZERO, fin);
                        return;
                    end
                    // minimum over minus one wraps back to the minimum
                    if (lhs == MIN_VALUE && rhs == -1)
                        res = lhs;
                    else
                        res = lhs / rhs;
                end
                default:
                begin
                    abort_expression(ST_UNKNOWN, fin);
                    return;
                end
            endcase
            eval_stack[eval_depth] = res;
            eval_depth++;
        end
        if (fin)
        begin
            if (eval_depth == 0)
                abort_expression(ST_UNDERFLOW, 1'b1);
            else
            begin
                expect_outcome(eval_stack[eval_depth-1], ST_OK);
                eval_depth = 0;
            end
        end
    endtask

    // Sample both handshakes, check results, run the watchdog
    always @(posedge clk)
    begin : monitor_blk
        outcome_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value %0d status %0d",
                                              value, status));
                else
                begin
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (value !== want.value || status !== want.status)
                        report_mismatch($sformatf("got value %0d status %0d, want %0d / %0d",
                                                  value, status, $signed(want.value),
                                                  want.status));
                end
                recv_wait = $urandom_range(0, rcv_gap_max);
            end
            if (push && !full)
                apply_symbol(symbol, last_symbol);
            if ((pop && !empty) || (push && !full))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: random stall after each popped result
    always @(negedge clk)
    begin
        if (recv_wait > 0)
        begin
            pop <= 1'b0;
            recv_wait--;
        end
        else
            pop <= 1'b1;
    end

    // Send one request; called and returns at a falling edge
    task send_symbol(input logic [7:0] sym, input logic fin);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        <= 1'b1;
        symbol      <= sym;
        last_symbol <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_pending();
        foreach (pending_bytes[i])
            send_symbol(pending_bytes[i], i == pending_bytes.size() - 1);
    endtask

    task send_text(input string s);
        pending_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
        send_pending();
    endtask

    // Hold off the sender until every expected result is back
    task wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Every operator, negative truncation, underflow, divide by zero, unknown symbol, drop after error
    task test_basics();
        send_text("9");
        send_text("12+");
        send_text("07-2/");
        send_text("56*");
        send_text("70/");
        send_text("+");
        send_text("5a7+");
        send_text("12x");
    endtask

    // Full stack, overflow on and before the last byte, leftovers below top
    task test_stack_limits();
        send_gap_max = 0;
        rcv_gap_max  = 0;
        pending_bytes.delete();
        repeat (STACK_DEPTH)
            pending_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        repeat (STACK_DEPTH - 1)
            pending_bytes.push_back(CH_PLUS);
        send_pending();
        send_gap_max = 8;
        rcv_gap_max  = 8;
        pending_bytes.delete();
        repeat (STACK_DEPTH + 1)
            pending_bytes.push_back(CH_NINE);
        send_pending();
        pending_bytes.push_back(CH_ZERO);
        send_pending();
        send_text("123");
    endtask

    // Build the minimum value from powers of two, then divide it by -1 and by 1
    task test_wrap_divide();
        wait_drained();
        for (int k = 0; k < 2; k++)
        begin
            pending_bytes.delete();
            pending_bytes.push_back("2");
            repeat (DATA_W - 2)
            begin
                pending_bytes.push_back("2");
                pending_bytes.push_back(CH_STAR);
            end
            if (k == 0)
            begin
                pending_bytes.push_back("0");
                pending_bytes.push_back("1");
                pending_bytes.push_back(CH_MINUS);
            end
            else
                pending_bytes.push_back("1");
            pending_bytes.push_back(CH_SLASH);
            send_pending();
        end
    endtask

    // Mostly well-formed expressions, some broken ones, some raw noise
    task send_random_expression();
        int kind;
        int operands;
        int pushed;
        int depth;
        int pos;
        pending_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
                pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            operands = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 6);
            pushed = 0;
            depth  = 0;
            while (pushed < operands || depth > 1)
            begin
                if (depth >= 2 && (pushed == operands || $urandom_range(0, 1) == 1))
                begin
                    pending_bytes.push_back(random_operator());
                    depth--;
                end
                else
                begin
                    pending_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    depth++;
                    pushed++;
                end
            end
            // corrupt one spot: replace, insert an operator, or drop a byte
            if (kind == 1)
            begin
                pos = $urandom_range(0, pending_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0:       pending_bytes[pos] = 8'($urandom_range(0, 255));
                    1:       pending_bytes.insert(pos, random_operator());
                    default: pending_bytes.delete(pos);
                endcase
                if (pending_bytes.size() == 0)
                    pending_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_pending();
    endtask

    task test_random_expressions();
        while (counted_symbols < TOTAL_SYMBOLS)
        begin
            // switch between idle-heavy and back-to-back stretches
            if ($urandom_range(0, 29) == 0)
            begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
                rcv_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_random_expression();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basics();
        test_stack_limits();
        test_wrap_divide();
        test_random_expressions();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d symbols evaluated, %0d dropped after errors, %0d results",
                 counted_symbols, dropped_symbols, results_seen);
        $display("status mix: ok %0d, overflow %0d, underflow %0d, div-by-zero %0d, unknown %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
